@@ src/svib_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svib_pkg: shared types and helpers for the segment versus inflated box test
// Coordinate widths, orientation codes and the small arithmetic helpers used
// by the single-pass intersection datapath.
// ----------------------------------------------------------------------------
package svib_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 9;
    localparam int SIDE_COUNT  = 4;

    // Grown box coordinates span from -(2^RADIUS_BITS - 1) up to
    // 2 * (2^COORD_BITS - 1) + 2^RADIUS_BITS - 1, which needs three more bits.
    localparam int POS_BITS   = COORD_BITS + 3;
    localparam int DIFF_BITS  = POS_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic [RADIUS_BITS-1:0]        radius_t;
    typedef logic [SIDE_COUNT-1:0]         side_mask_t;
    typedef logic signed [POS_BITS-1:0]    pos_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [CROSS_BITS-1:0]  cross_t;
    typedef logic [1:0]                    turn_t;

    // Orientation codes.
    localparam turn_t TURN_COLL = 2'b00;
    localparam turn_t TURN_CCW  = 2'b01;
    localparam turn_t TURN_CW   = 2'b10;

    // Side bit positions in the hit mask.
    localparam int SIDE_WEST  = 0;
    localparam int SIDE_SOUTH = 1;
    localparam int SIDE_EAST  = 2;
    localparam int SIDE_NORTH = 3;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t left;
        coord_t top;
        coord_t width;
        coord_t height;
    } seg_box_t;

    // Orientation of corner c seen from the segment a-b.
    function automatic turn_t corner_turn(input pos_t ax, input pos_t ay,
                                          input pos_t bx, input pos_t by,
                                          input pos_t cx, input pos_t cy);
        diff_t  dx_seg;
        diff_t  dy_seg;
        diff_t  dx_c;
        diff_t  dy_c;
        prod_t  p_one;
        prod_t  p_two;
        cross_t v;
        dx_seg = diff_t'(bx) - diff_t'(ax);
        dy_seg = diff_t'(by) - diff_t'(ay);
        dx_c   = diff_t'(cx) - diff_t'(bx);
        dy_c   = diff_t'(cy) - diff_t'(by);
        p_one  = prod_t'(dy_seg) * prod_t'(dx_c);
        p_two  = prod_t'(dx_seg) * prod_t'(dy_c);
        v      = cross_t'(p_one) - cross_t'(p_two);
        if (v == '0)
            return TURN_COLL;
        else if (v[CROSS_BITS-1])
            return TURN_CW;
        else
            return TURN_CCW;
    endfunction

    // Orientation of a point against an axis-aligned side. The side's own
    // length is never negative, so only its zero case and the point's offset
    // from the side's line matter. Horizontal sides flip the sign.
    function automatic turn_t side_turn(input logic degen, input pos_t p,
                                        input pos_t line_pos, input logic flip);
        if (degen || (p == line_pos))
            return TURN_COLL;
        else if ((p > line_pos) ^ flip)
            return TURN_CCW;
        else
            return TURN_CW;
    endfunction

    // True when v lies between the two bounds, in either order.
    function automatic logic in_span(input pos_t v, input pos_t e0, input pos_t e1);
        pos_t lo;
        pos_t hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return (v >= lo) && (v <= hi);
    endfunction

    // Segment crossing decision from the four orientations and the
    // collinear on-segment checks.
    function automatic logic seg_cross(input turn_t o1, input turn_t o2,
                                       input turn_t o3, input turn_t o4,
                                       input logic c_in, input logic d_in,
                                       input logic a_in, input logic b_in);
        return ((o1 != o2) && (o3 != o4))
            || ((o1 == TURN_COLL) && c_in)
            || ((o2 == TURN_COLL) && d_in)
            || ((o3 == TURN_COLL) && a_in)
            || ((o4 == TURN_COLL) && b_in);
    endfunction

endpackage
`default_nettype wire

@@ src/segment_vs_inflated_box_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_vs_inflated_box_test: segment against grown obstacle box
// Grows an axis-aligned box by a configured radius and reports which of its
// four sides a segment touches, using orientation tests.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid/in_ready) carries one segment A-B
// and one obstacle box. The box is grown by inflate_radius on every side and
// the segment is tested against the west, south, east and north sides. The
// answer leaves on the output channel (out_valid/out_ready) as a four-bit
// side mask plus a blocked flag that is set when any side is touched.
// Touching, collinear overlap and point segments all count as hits.
// A request passes through one request register, then one pass of orientation
// logic into the result register. Throughput is one request per cycle while the
// receiver keeps up; the four corner cross products (two multiplies each) are
// computed in parallel in that single pass.
// When the receiver stalls, the result register holds its request and the
// input register fills behind it, so in_ready drops only when both are full.
// Reset clears both valid flags and sets the radius to zero. The radius is
// written through cfg_wr_en/cfg_wr_data and must only change while no request
// is in flight.
// ----------------------------------------------------------------------------
module segment_vs_inflated_box_test (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire svib_pkg::radius_t    cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire svib_pkg::coord_t     seg_ax,
    input  wire svib_pkg::coord_t     seg_ay,
    input  wire svib_pkg::coord_t     seg_bx,
    input  wire svib_pkg::coord_t     seg_by,
    input  wire svib_pkg::coord_t     box_left,
    input  wire svib_pkg::coord_t     box_top,
    input  wire svib_pkg::coord_t     box_width,
    input  wire svib_pkg::coord_t     box_height,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output svib_pkg::side_mask_t      side_hits,
    output logic                      blocked
);
    import svib_pkg::*;

    // Configuration and pipeline registers.
    radius_t    radius_reg;
    seg_box_t   req_reg;
    logic       req_valid_reg;
    logic       req_valid_next;
    side_mask_t hits_reg;
    logic       blocked_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic       in_accept;
    logic       req_advance;

    // Positions in the signed working width.
    pos_t ax, ay, bx, by;
    pos_t w_pos, e_pos, n_pos, s_pos;

    // Orientation of each grown-box corner against the segment.
    turn_t t_nw, t_sw, t_se, t_ne;

    // Corner-in-segment-bounds flags.
    logic w_in_seg_x, e_in_seg_x, n_in_seg_y, s_in_seg_y;

    // Endpoint relation to the sides.
    logic ns_flat, we_flat;
    logic a_in_ns, b_in_ns, a_in_we, b_in_we;

    side_mask_t hits_next;

    // ------------------------------------------------------------------
    // Handshake: the request register advances whenever the result
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    assign req_advance    = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !req_valid_reg || req_advance;
    assign in_accept      = in_valid && in_ready;
    assign req_valid_next = in_accept || (req_valid_reg && !req_advance);
    assign out_valid_next = req_advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= '0;
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.ax     <= seg_ax;
            req_reg.ay     <= seg_ay;
            req_reg.bx     <= seg_bx;
            req_reg.by     <= seg_by;
            req_reg.left   <= box_left;
            req_reg.top    <= box_top;
            req_reg.width  <= box_width;
            req_reg.height <= box_height;
        end
        if (req_advance)
        begin
            hits_reg    <= hits_next;
            blocked_reg <= |hits_next;
        end
    end

    // ------------------------------------------------------------------
    // Grown box. Inputs are unsigned, so the size casts zero-extend.
    // ------------------------------------------------------------------
    always_comb
    begin
        ax    = pos_t'(req_reg.ax);
        ay    = pos_t'(req_reg.ay);
        bx    = pos_t'(req_reg.bx);
        by    = pos_t'(req_reg.by);
        w_pos = pos_t'(req_reg.left) - pos_t'(radius_reg);
        e_pos = pos_t'(req_reg.left) + pos_t'(req_reg.width) + pos_t'(radius_reg);
        n_pos = pos_t'(req_reg.top) - pos_t'(radius_reg);
        s_pos = pos_t'(req_reg.top) + pos_t'(req_reg.height) + pos_t'(radius_reg);
    end

    // ------------------------------------------------------------------
    // Orientation of the four corners relative to the segment. Each side
    // shares its two corners with neighbors, so four cross products cover
    // all eight segment-side orientations.
    // ------------------------------------------------------------------
    assign t_nw = corner_turn(ax, ay, bx, by, w_pos, n_pos);
    assign t_sw = corner_turn(ax, ay, bx, by, w_pos, s_pos);
    assign t_se = corner_turn(ax, ay, bx, by, e_pos, s_pos);
    assign t_ne = corner_turn(ax, ay, bx, by, e_pos, n_pos);

    assign w_in_seg_x = in_span(w_pos, ax, bx);
    assign e_in_seg_x = in_span(e_pos, ax, bx);
    assign n_in_seg_y = in_span(n_pos, ay, by);
    assign s_in_seg_y = in_span(s_pos, ay, by);

    // The grown box always has north above or equal to south and west left
    // of or equal to east, so the side spans need no ordering.
    assign ns_flat = (s_pos == n_pos);
    assign we_flat = (e_pos == w_pos);
    assign a_in_ns = (ay >= n_pos) && (ay <= s_pos);
    assign b_in_ns = (by >= n_pos) && (by <= s_pos);
    assign a_in_we = (ax >= w_pos) && (ax <= e_pos);
    assign b_in_we = (bx >= w_pos) && (bx <= e_pos);

    // ------------------------------------------------------------------
    // Per-side decisions. Vertical sides see the endpoints through their x
    // offset, horizontal sides through their y offset with the sign flipped.
    // ------------------------------------------------------------------
    always_comb
    begin
        hits_next = '0;
        hits_next[SIDE_WEST] = seg_cross(
            t_nw, t_sw,
            side_turn(ns_flat, ax, w_pos, 1'b0), side_turn(ns_flat, bx, w_pos, 1'b0),
            w_in_seg_x && n_in_seg_y, w_in_seg_x && s_in_seg_y,
            (ax == w_pos) && a_in_ns, (bx == w_pos) && b_in_ns);
        hits_next[SIDE_SOUTH] = seg_cross(
            t_sw, t_se,
            side_turn(we_flat, ay, s_pos, 1'b1), side_turn(we_flat, by, s_pos, 1'b1),
            w_in_seg_x && s_in_seg_y, e_in_seg_x && s_in_seg_y,
            (ay == s_pos) && a_in_we, (by == s_pos) && b_in_we);
        hits_next[SIDE_EAST] = seg_cross(
            t_ne, t_se,
            side_turn(ns_flat, ax, e_pos, 1'b0), side_turn(ns_flat, bx, e_pos, 1'b0),
            e_in_seg_x && n_in_seg_y, e_in_seg_x && s_in_seg_y,
            (ax == e_pos) && a_in_ns, (bx == e_pos) && b_in_ns);
        hits_next[SIDE_NORTH] = seg_cross(
            t_nw, t_ne,
            side_turn(we_flat, ay, n_pos, 1'b1), side_turn(we_flat, by, n_pos, 1'b1),
            w_in_seg_x && n_in_seg_y, e_in_seg_x && n_in_seg_y,
            (ay == n_pos) && a_in_we, (by == n_pos) && b_in_we);
    end

    assign out_valid = out_valid_reg;
    assign side_hits = hits_reg;
    assign blocked   = blocked_reg;

`ifndef SYNTHESIS
    // The input side only stalls when both pipeline registers are occupied.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (req_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline slot");

    // A ready receiver never back-pressures the input channel.
    a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input not ready while output is ready");

    // An accepted request reaches the output through the request and result registers when not stalled.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready ##1 out_ready) |=> out_valid)
        else $error("request did not reach the output in two cycles");

    // The blocked flag always agrees with the delivered side mask.
    a_blocked_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blocked == (side_hits != '0)))
        else $error("blocked flag disagrees with side mask");
`endif

endmodule
`default_nettype wire
